// ===== hdl/mla_pkg.sv =====
// Shared types, codes and helpers for the multi-line async adapter.
// No dependencies; used by mla_line_file and multiline_async_adapter_unit.
`default_nettype none

package mla_pkg;

    localparam int MLA_LINES = 32;

    // Item kinds carried in s_tuser
    typedef enum logic [3:0] {
        KIND_READ       = 4'd0,
        KIND_WRITE      = 4'd1,
        KIND_STATUS     = 4'd2,
        KIND_COMMAND    = 4'd3,
        KIND_RX_CHAR    = 4'd4,
        KIND_RX_BREAK   = 4'd5,
        KIND_TX_DONE    = 4'd6,
        KIND_CONNECT    = 4'd7,
        KIND_DISCONNECT = 4'd8
    } kind_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_MODEM_CONTROL  = 2'd0;
    localparam logic [1:0] CFG_EIGHT_BIT_MODE = 2'd1;
    localparam logic [1:0] CFG_LINES_ENABLED  = 2'd2;

    // Status byte bits
    localparam logic [7:0] ST_OVR      = 8'h80;
    localparam logic [7:0] ST_NCS      = 8'h40;
    localparam logic [7:0] ST_PF       = 8'h40;
    localparam logic [7:0] ST_FR       = 8'h20;
    localparam logic [7:0] ST_RCV_MASK = 8'hF3;
    localparam logic [7:0] ST_EXC_SRC  = 8'hE0;
    localparam logic [7:0] ST_BSY      = 8'h08;
    localparam logic [7:0] ST_EX       = 8'h04;
    localparam logic [7:0] ST_CROF     = 8'h02;
    localparam logic [7:0] ST_RING     = 8'h01;

    // Command word bits
    localparam int CW_DTR_BIT  = 13;
    localparam int CW_ECHO_BIT = 12;
    localparam int CW_WRT_BIT  = 9;

    // Arm/enable codes in command byte bits 7:6
    localparam logic [1:0] ARM_NONE    = 2'd0;
    localparam logic [1:0] ARM_ENABLE  = 2'd1;
    localparam logic [1:0] ARM_DISABLE = 2'd2;
    localparam logic [1:0] ARM_OFF     = 2'd3;

    localparam logic [1:0] PARSEL_ODD  = 2'd2;
    localparam logic [1:0] PARSEL_EVEN = 2'd3;

    typedef struct packed {
        kind_t      kind;
        logic [4:0] line;
        logic       side;
        logic [7:0] data;
        logic       tx_space;
    } item_t;

    typedef struct packed {
        logic [7:0] read_value;
        logic       out_valid;
        logic [7:0] out_char;
        logic       tx_retry;
        logic       irq_valid;
        logic [5:0] irq_vector;
        logic       hangup;
    } result_t;

    typedef struct packed {
        logic       modem_control;
        logic       eight_bit_mode;
        logic [5:0] lines_enabled;
    } cfg_t;

    // Parity insertion on the low seven bits; parity select is cw bits 2:1
    function automatic logic [7:0] add_parity(input logic [15:0] cw, input logic [7:0] ch);
        logic [1:0] sel;
        logic       odd_ones;
        logic [7:0] res;
        sel      = cw[2:1];
        odd_ones = ^ch[6:0];
        case (sel)
            PARSEL_ODD:  res = {~odd_ones, ch[6:0]};
            PARSEL_EVEN: res = {odd_ones, ch[6:0]};
            default:     res = ch;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/mla_line_file.sv =====
// Per-line state of the adapter and the single-pass update for one transaction.
// Depends on mla_pkg.
`default_nettype none

module mla_line_file #(
    parameter int LINES = mla_pkg::MLA_LINES
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               go,
    input  mla_pkg::cfg_t     cfg,
    input  mla_pkg::item_t    item,
    output mla_pkg::result_t  res
);
    import mla_pkg::*;

    localparam int IDX_W = (LINES > 1) ? $clog2(LINES) : 1;
    localparam logic [5:0] LINES_6 = 6'(LINES);

    logic [7:0]  status_reg  [LINES];
    logic [15:0] cmd_reg     [LINES];
    logic [7:0]  rbuf_reg    [LINES];
    logic [7:0]  tbuf_reg    [LINES];
    logic        rarm_reg    [LINES];
    logic        tarm_reg    [LINES];
    logic        pend_reg    [LINES];
    logic [1:0]  ien_reg     [LINES];
    logic        conn_reg    [LINES];

    logic [IDX_W-1:0] idx;
    logic [5:0]       used;
    logic             in_use;

    logic [7:0]  st, st_next;
    logic [15:0] cw, cw_next;
    logic [7:0]  rbuf, rbuf_next;
    logic [7:0]  tbuf, tbuf_next;
    logic        rarm, rarm_next;
    logic        tarm, tarm_next;
    logic        pend, pend_next;
    logic [1:0]  ien, ien_next;
    logic        conn, conn_next;
    logic [7:0]  t;
    logic [1:0]  code;

    assign idx    = item.line[IDX_W-1:0];
    assign used   = (cfg.lines_enabled > LINES_6) ? LINES_6 : cfg.lines_enabled;
    assign in_use = ({1'b0, item.line} < used) && ({1'b0, item.line} < LINES_6);

    assign st   = status_reg[idx];
    assign cw   = cmd_reg[idx];
    assign rbuf = rbuf_reg[idx];
    assign tbuf = tbuf_reg[idx];
    assign rarm = rarm_reg[idx];
    assign tarm = tarm_reg[idx];
    assign pend = pend_reg[idx];
    assign ien  = ien_reg[idx];
    assign conn = conn_reg[idx];
    assign code = item.data[7:6];

    always_comb begin
        st_next   = st;
        cw_next   = cw;
        rbuf_next = rbuf;
        tbuf_next = tbuf;
        rarm_next = rarm;
        tarm_next = tarm;
        pend_next = pend;
        ien_next  = ien;
        conn_next = conn;
        res       = '0;
        t         = '0;
        if (in_use) begin
            case (item.kind)
                KIND_READ: begin
                    pend_next      = 1'b0;
                    st_next        = st & ~ST_OVR;
                    res.read_value = rbuf;
                end
                KIND_WRITE: begin
                    tbuf_next = item.data;
                    st_next   = st | ST_BSY;
                end
                KIND_STATUS: begin
                    if (item.side) begin
                        t = conn ? (st & ST_BSY) : (ST_NCS | ST_BSY);
                    end else begin
                        t = st & ST_RCV_MASK;
                        if (!pend) t = t | ST_BSY;
                        if (!conn) t = t | ST_BSY | ST_EX;
                        if ((t & ST_EXC_SRC) != 8'h00) t = t | ST_EX;
                    end
                    res.read_value = t;
                end
                KIND_COMMAND: begin
                    if (item.data[0]) begin
                        cw_next = {item.data, cw[7:0]};
                        // bit 9 of the new word picks the side the arm code applies to
                        if (cw_next[CW_WRT_BIT]) begin
                            case (code)
                                ARM_ENABLE:  begin ien_next[1] = 1'b1; tarm_next = 1'b1; end
                                ARM_DISABLE: begin ien_next[1] = 1'b0; tarm_next = 1'b1; end
                                ARM_OFF:     begin ien_next[1] = 1'b0; tarm_next = 1'b0; end
                                default:     ;
                            endcase
                        end else begin
                            case (code)
                                ARM_ENABLE:  begin ien_next[0] = 1'b1; rarm_next = 1'b1; end
                                ARM_DISABLE: begin ien_next[0] = 1'b0; rarm_next = 1'b1; end
                                ARM_OFF:     begin ien_next[0] = 1'b0; rarm_next = 1'b0; end
                                default:     ;
                            endcase
                        end
                    end else begin
                        cw_next = {cw[15:8], item.data};
                    end
                    if (cfg.modem_control) begin
                        if (cw_next[CW_DTR_BIT] && st[0])
                            st_next = st & ~(ST_CROF | ST_RING);
                        // DTR falling drops the line
                        if (cw[CW_DTR_BIT] && !cw_next[CW_DTR_BIT]) begin
                            conn_next  = 1'b0;
                            st_next    = st_next | ST_CROF;
                            res.hangup = 1'b1;
                            if (rarm_next && ien_next[0]) begin
                                res.irq_valid  = 1'b1;
                                res.irq_vector = {item.line, 1'b0};
                            end
                        end
                    end
                end
                KIND_RX_CHAR, KIND_RX_BREAK: begin
                    if (conn) begin
                        st_next = st & ~(ST_FR | ST_PF);
                        if (pend) st_next = st_next | ST_OVR;
                        if (rarm && ien[0]) begin
                            res.irq_valid  = 1'b1;
                            res.irq_vector = {item.line, 1'b0};
                        end
                        if (item.kind == KIND_RX_BREAK) begin
                            st_next   = st_next | ST_FR;
                            rbuf_next = 8'h00;
                        end else begin
                            rbuf_next = cfg.eight_bit_mode ? item.data
                                      : add_parity(cw, {1'b0, item.data[6:0]});
                            pend_next = 1'b1;
                            if (cw[CW_ECHO_BIT] && item.tx_space) begin
                                res.out_valid = 1'b1;
                                res.out_char  = {1'b0, item.data[6:0]};
                            end
                        end
                    end
                end
                KIND_TX_DONE: begin
                    if (conn && !item.tx_space) begin
                        res.tx_retry = 1'b1;
                    end else begin
                        if (conn) begin
                            res.out_valid = 1'b1;
                            res.out_char  = cfg.eight_bit_mode ? add_parity(cw, tbuf)
                                          : {1'b0, tbuf[6:0]};
                        end
                        st_next = st & ~ST_BSY;
                        if (tarm && ien[1]) begin
                            res.irq_valid  = 1'b1;
                            res.irq_vector = {item.line, 1'b1};
                        end
                    end
                end
                KIND_CONNECT: begin
                    if (cfg.modem_control && !cw[CW_DTR_BIT])
                        st_next = st | ST_RING | ST_CROF;
                    else
                        st_next = st & ~ST_CROF;
                    if (rarm && ien[0]) begin
                        res.irq_valid  = 1'b1;
                        res.irq_vector = {item.line, 1'b0};
                    end
                    conn_next = 1'b1;
                end
                KIND_DISCONNECT: begin
                    conn_next = 1'b0;
                    if ((st & ST_CROF) == 8'h00) begin
                        st_next = st | ST_CROF;
                        if (rarm && ien[0]) begin
                            res.irq_valid  = 1'b1;
                            res.irq_vector = {item.line, 1'b0};
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LINES; i++) begin
                status_reg[i] <= ST_CROF;
                cmd_reg[i]    <= '0;
                rbuf_reg[i]   <= '0;
                tbuf_reg[i]   <= '0;
                rarm_reg[i]   <= 1'b0;
                tarm_reg[i]   <= 1'b0;
                pend_reg[i]   <= 1'b0;
                ien_reg[i]    <= '0;
                conn_reg[i]   <= 1'b0;
            end
        end else if (go && in_use) begin
            status_reg[idx] <= st_next;
            cmd_reg[idx]    <= cw_next;
            rbuf_reg[idx]   <= rbuf_next;
            tbuf_reg[idx]   <= tbuf_next;
            rarm_reg[idx]   <= rarm_next;
            tarm_reg[idx]   <= tarm_next;
            pend_reg[idx]   <= pend_next;
            ien_reg[idx]    <= ien_next;
            conn_reg[idx]   <= conn_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/multiline_async_adapter_unit.sv =====
// Top level of the multi-line async adapter: stream ports, configuration
// registers, input and result registers. Depends on mla_pkg and mla_line_file.
`default_nettype none

// Per-line register file for up to LINES asynchronous lines. Each input
// transaction is one bus access (read, write, status sense, output command)
// or one line event (character, break, transmit done, connect, disconnect),
// and produces exactly one result transaction. The block accepts a new
// transaction every cycle while results are taken. A transaction waits in
// the input register until the result register is free; then the line's
// state is read, updated and written back while the result register loads,
// and the result is offered on m_tdata. The line state lives in flip-flops,
// so back-to-back transactions on the same line see each other's updates
// with no hazard. The result register holds under m_tready low while the
// input register keeps taking one more transaction.
// Lines at or above lines_enabled (or LINES) leave state untouched and
// return an all-zero result. Configuration is written through cfg_we /
// cfg_addr / cfg_wdata and should only change while no transaction is in
// flight.
module multiline_async_adapter_unit #(
    parameter int LINES = mla_pkg::MLA_LINES
) (
    input  wire         aclk,
    input  wire         aresetn,
    // input stream
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,   // line[4:0], side[5], data[13:6], tx_space[14], zero[15]
    input  wire  [3:0]  s_tuser,   // kind[3:0]
    // result stream
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,   // read_value[7:0], out_valid[8], out_char[16:9],
                                   // tx_retry[17], irq_valid[18], irq_vector[24:19],
                                   // hangup[25], zero[31:26]
    // configuration writes
    input  wire         cfg_we,
    input  wire  [1:0]  cfg_addr,
    input  wire  [5:0]  cfg_wdata
);
    import mla_pkg::*;

    cfg_t    cfg_reg;
    logic    in_v_reg, in_v_next;
    item_t   item_reg;
    logic    out_v_reg, out_v_next;
    result_t res_reg;
    result_t res;
    logic    s_accept;
    logic    adv;   // input register moves into the result register

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.modem_control  <= 1'b0;
            cfg_reg.eight_bit_mode <= 1'b0;
            cfg_reg.lines_enabled  <= 6'd8;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_MODEM_CONTROL:  cfg_reg.modem_control  <= cfg_wdata[0];
                CFG_EIGHT_BIT_MODE: cfg_reg.eight_bit_mode <= cfg_wdata[0];
                CFG_LINES_ENABLED:  cfg_reg.lines_enabled  <= cfg_wdata;
                default:            ;
            endcase
        end
    end

    // handshake: input register frees up whenever its transaction can move on
    assign adv      = in_v_reg && (!out_v_reg || m_tready);
    assign s_tready = !in_v_reg || adv;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_v_next = in_v_reg;
        if (s_accept)
            in_v_next = 1'b1;
        else if (adv)
            in_v_next = 1'b0;

        out_v_next = out_v_reg;
        if (adv)
            out_v_next = 1'b1;
        else if (m_tready)
            out_v_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            in_v_reg  <= in_v_next;
            out_v_reg <= out_v_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg.kind     <= kind_t'(s_tuser);
            item_reg.line     <= s_tdata[4:0];
            item_reg.side     <= s_tdata[5];
            item_reg.data     <= s_tdata[13:6];
            item_reg.tx_space <= s_tdata[14];
        end
        if (adv)
            res_reg <= res;
    end

    mla_line_file #(
        .LINES (LINES)
    ) u_line_file (
        .aclk    (aclk),
        .aresetn (aresetn),
        .go      (adv),
        .cfg     (cfg_reg),
        .item    (item_reg),
        .res     (res)
    );

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {6'b0, res_reg.hangup, res_reg.irq_vector, res_reg.irq_valid,
                       res_reg.tx_retry, res_reg.out_char, res_reg.out_valid,
                       res_reg.read_value};

endmodule

`default_nettype wire
